/* rtl/ifa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to formatted ASCII: shared package
// Types, codes, character constants and the digit lookup used by the
// formatter and its digit unit.
// ----------------------------------------------------------------------------
package ifa_pkg;

  // Default bounds for field width and precision.
  localparam int MAX_WIDTH_DEF     = 60;
  localparam int MAX_PRECISION_DEF = 32;

  // Binary to BCD conversion covers a full 64-bit magnitude.
  localparam int BIN_W       = 64;
  localparam int BCD_DIGITS  = 20;
  localparam int BCD_W       = 4 * BCD_DIGITS;

  // Most significant digits of any conversion: 64 bits in octal.
  localparam int DIGIT_DEPTH = 22;
  localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH);
  localparam int DIGIT_CNT_W = $clog2(DIGIT_DEPTH + 1);

  // Shift-and-adjust steps for wide and narrow values.
  localparam int DABBLE_WIDE   = 64;
  localparam int DABBLE_NARROW = 32;
  localparam int STEP_W        = $clog2(DABBLE_WIDE);

  // Fixed precision for the pointer conversion.
  localparam int PTR_PRECISION = 8;

  // ASCII codes used by the formatter.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Conversion codes.
  typedef enum logic [2:0] {
    OP_DEC  = 3'd0,
    OP_UNS  = 3'd1,
    OP_OCT  = 3'd2,
    OP_LHEX = 3'd3,
    OP_UHEX = 3'd4,
    OP_PTR  = 3'd5
  } ifa_op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_EXTRACT,
    ST_SIZE,
    ST_PAD,
    ST_PLACE,
    ST_EMIT,
    ST_EMPTY
  } ifa_state_e;

  // Commands from the sequencer to the digit unit.
  typedef struct packed {
    logic load;
    logic dec;
    logic wide;
    logic dabble;
    logic shift;
    logic oct;
  } ifa_digit_cmd_t;

  // Status from the digit unit.
  typedef struct packed {
    logic [3:0] digit;
    logic       is_zero;
  } ifa_digit_sts_t;

  // One digit value to its ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'd0, d};
    end else begin
      ch = (upper ? CH_UP_A : CH_LOW_A) + {4'd0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

/* rtl/ifa_digit_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to formatted ASCII: digit unit
// Holds the magnitude and runs one shared shift step per cycle: either a
// binary to BCD shift-and-adjust step, or the removal of the lowest digit.
// ----------------------------------------------------------------------------
module ifa_digit_unit (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ifa_pkg::ifa_digit_cmd_t cmd_i,
  input  wire logic [63:0]             mag_i,
  output      ifa_pkg::ifa_digit_sts_t sts_o
);

  logic [ifa_pkg::BCD_W-1:0] bcd_q, bcd_d;
  logic [ifa_pkg::BIN_W-1:0] bin_q, bin_d;
  logic [ifa_pkg::BCD_W-1:0] adj;

  // Add three to every BCD digit of five or more ahead of the shift.
  always_comb begin
    for (int i = 0; i < ifa_pkg::BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                 : bcd_q[4*i +: 4];
    end
  end

  // Load, shift-and-adjust, or drop the lowest digit.
  always_comb begin
    bcd_d = bcd_q;
    bin_d = bin_q;
    if (cmd_i.load) begin
      if (cmd_i.dec) begin
        bcd_d = '0;
        bin_d = cmd_i.wide ? mag_i : {mag_i[31:0], 32'd0};
      end else begin
        bcd_d = {{(ifa_pkg::BCD_W - ifa_pkg::BIN_W){1'b0}}, mag_i};
      end
    end else if (cmd_i.dabble) begin
      bcd_d = {adj[ifa_pkg::BCD_W-2:0], bin_q[ifa_pkg::BIN_W-1]};
      bin_d = {bin_q[ifa_pkg::BIN_W-2:0], 1'b0};
    end else if (cmd_i.shift) begin
      bcd_d = cmd_i.oct ? (bcd_q >> 3) : (bcd_q >> 4);
    end
  end

  // Working registers carry data only.
  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
  end

  // Lowest digit in the current base and the end-of-digits flag.
  assign sts_o.digit   = cmd_i.oct ? {1'b0, bcd_q[2:0]} : bcd_q[3:0];
  assign sts_o.is_zero = (bcd_q == '0);

  // The load and the step commands are never issued together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.load |-> !(cmd_i.dabble || cmd_i.shift))
    else $error("digit unit load collides with a step");

  // Drop a digit only while one remains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.shift |-> !sts_o.is_zero)
    else $error("digit unit shifted an exhausted magnitude");

  // A decimal load clears the BCD field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cmd_i.load && cmd_i.dec) |=> sts_o.is_zero)
    else $error("digit unit BCD field not cleared on load");

endmodule
`default_nettype wire

/* rtl/integer_to_formatted_ascii_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to formatted ASCII unit
// Converts one integer under a printf style integer spec into a stream of
// ASCII characters, one word per character, the final one marked.
// ----------------------------------------------------------------------------
// One input word is taken while the unit is idle; it then stalls its input
// until the last character has been loaded into the output register. A
// decimal conversion first runs the shared shift-and-adjust unit for one
// step per bit of a wide or a narrow value (octal and hex skip this), then
// removes one digit per cycle (up to 22) until the magnitude is seen
// exhausted, sizes the field in the SIZE, PAD and PLACE states, and emits
// one character per cycle while the output is not stalled, up to PosMax.
// An empty conversion gives a single word with last and empty_res set.
// ----------------------------------------------------------------------------
module integer_to_formatted_ascii_unit #(
  parameter int MAX_WIDTH     = ifa_pkg::MAX_WIDTH_DEF,
  parameter int MAX_PRECISION = ifa_pkg::MAX_PRECISION_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [63:0] value_i,
  input  wire logic        wide_i,
  input  wire logic [2:0]  opcode_i,
  input  wire logic        left_justify_i,
  input  wire logic        plus_sign_i,
  input  wire logic        space_sign_i,
  input  wire logic        alt_form_i,
  input  wire logic        zero_pad_i,
  input  wire logic [5:0]  field_width_i,
  input  wire logic [5:0]  digit_count_i,
  input  wire logic        count_given_i,
  // Output channel
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  out_char_o,
  output      logic        last_o,
  output      logic        empty_res_o
);

  // Longest digit string plus sign, or the widest field, plus the prefix.
  localparam int DigMax = (MAX_PRECISION > ifa_pkg::DIGIT_DEPTH) ? MAX_PRECISION
                                                                 : ifa_pkg::DIGIT_DEPTH;
  localparam int PosMax = ((MAX_WIDTH > DigMax + 1) ? MAX_WIDTH : DigMax + 1) + 2;
  localparam int PW     = $clog2(PosMax + 1);

  ifa_pkg::ifa_state_e state_q, state_d;

  // Control registers
  logic [ifa_pkg::STEP_W-1:0]      step_q;
  logic [ifa_pkg::DIGIT_CNT_W-1:0] nd_q;
  logic [PW-1:0]                   k_q;
  logic                            out_valid_q;

  // Per-item payload registers
  logic          wide_q, dec_q, oct_q, upper_q, sgn_q, alt_q, left_q, zero_q;
  logic [7:0]    sign_char_q;
  logic [PW-1:0] width_q, prec_q;
  logic [PW-1:0] nd_tot_q, body_q, pad_q;
  logic [PW-1:0] lead_q, s_end_q, a_end_q, z_end_q, d_end_q, total_q;
  logic [7:0]    out_char_q;
  logic          out_last_q, out_empty_q;
  logic [3:0]    digit_buf_q [ifa_pkg::DIGIT_DEPTH];

  ifa_pkg::ifa_digit_cmd_t dcmd;
  ifa_pkg::ifa_digit_sts_t dsts;

  logic          accept, slot_free, op_bad, neg;
  logic [63:0]   mag;
  logic [PW-1:0] lead_c, s_end_c, a_end_c, z_end_c, d_end_c, total_c;
  logic [PW-1:0] idx;
  logic [7:0]    emit_char;

  assign accept    = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign op_bad    = opcode_i > 3'(ifa_pkg::OP_PTR);

  // Signed narrow values print their two's complement magnitude.
  assign neg = !wide_i && (opcode_i == ifa_pkg::OP_DEC) && value_i[31];
  assign mag = wide_i ? value_i
                      : {32'd0, neg ? (~value_i[31:0] + 32'd1) : value_i[31:0]};

  ifa_digit_unit u_digit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (dcmd),
    .mag_i  (mag),
    .sts_o  (dsts)
  );

  // Field layout from the padded digit string.
  always_comb begin
    lead_c  = (!left_q && !zero_q) ? pad_q : '0;
    s_end_c = lead_c + PW'(sgn_q);
    a_end_c = s_end_c + (alt_q ? PW'(2) : PW'(0));
    z_end_c = a_end_c + ((!left_q && zero_q) ? pad_q : PW'(0));
    d_end_c = z_end_c + nd_tot_q;
    total_c = d_end_c + (left_q ? pad_q : PW'(0));
  end

  // Character at the current position of the field.
  always_comb begin
    idx = d_end_q - PW'(1) - k_q;
    if (k_q < lead_q) begin
      emit_char = ifa_pkg::CH_SPACE;
    end else if (k_q < s_end_q) begin
      emit_char = sign_char_q;
    end else if (k_q < a_end_q) begin
      emit_char = (k_q == s_end_q) ? ifa_pkg::CH_ZERO : ifa_pkg::CH_LOW_X;
    end else if (k_q < z_end_q) begin
      emit_char = ifa_pkg::CH_ZERO;
    end else if (k_q < d_end_q) begin
      emit_char = (idx < PW'(nd_q))
                  ? ifa_pkg::digit_char(digit_buf_q[idx[ifa_pkg::DIGIT_IDX_W-1:0]], upper_q)
                  : ifa_pkg::CH_ZERO;
    end else begin
      emit_char = ifa_pkg::CH_SPACE;
    end
  end

  // Sequencer: next state and digit unit commands.
  always_comb begin
    state_d     = state_q;
    dcmd        = '0;
    dcmd.load   = accept;
    dcmd.dec    = (opcode_i == ifa_pkg::OP_DEC) || (opcode_i == ifa_pkg::OP_UNS);
    dcmd.wide   = wide_i;
    dcmd.oct    = oct_q;
    unique case (state_q)
      ifa_pkg::ST_IDLE: begin
        if (accept) begin
          if (op_bad) begin
            state_d = ifa_pkg::ST_EMPTY;
          end else if (dcmd.dec) begin
            state_d = ifa_pkg::ST_DABBLE;
          end else begin
            state_d = ifa_pkg::ST_EXTRACT;
          end
        end
      end
      ifa_pkg::ST_DABBLE: begin
        dcmd.dabble = 1'b1;
        if (step_q == (wide_q ? ifa_pkg::STEP_W'(ifa_pkg::DABBLE_WIDE - 1)
                              : ifa_pkg::STEP_W'(ifa_pkg::DABBLE_NARROW - 1))) begin
          state_d = ifa_pkg::ST_EXTRACT;
        end
      end
      ifa_pkg::ST_EXTRACT: begin
        if (dsts.is_zero) begin
          state_d = ifa_pkg::ST_SIZE;
        end else begin
          dcmd.shift = 1'b1;
        end
      end
      ifa_pkg::ST_SIZE: begin
        state_d = ifa_pkg::ST_PAD;
      end
      ifa_pkg::ST_PAD: begin
        state_d = ifa_pkg::ST_PLACE;
      end
      ifa_pkg::ST_PLACE: begin
        state_d = (total_c == '0) ? ifa_pkg::ST_EMPTY : ifa_pkg::ST_EMIT;
      end
      ifa_pkg::ST_EMIT: begin
        if (slot_free && (k_q == total_q - PW'(1))) begin
          state_d = ifa_pkg::ST_IDLE;
        end
      end
      ifa_pkg::ST_EMPTY: begin
        if (slot_free) begin
          state_d = ifa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ifa_pkg::ST_IDLE;
      end
    endcase
  end

  // State, counters and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ifa_pkg::ST_IDLE;
      step_q      <= '0;
      nd_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
        nd_q   <= '0;
      end
      if (state_q == ifa_pkg::ST_DABBLE) begin
        step_q <= step_q + ifa_pkg::STEP_W'(1);
      end
      if (dcmd.shift) begin
        nd_q <= nd_q + ifa_pkg::DIGIT_CNT_W'(1);
      end
      if (state_q == ifa_pkg::ST_PLACE) begin
        k_q <= '0;
      end else if (state_q == ifa_pkg::ST_EMIT && slot_free) begin
        k_q <= k_q + PW'(1);
      end
      if ((state_q == ifa_pkg::ST_EMIT || state_q == ifa_pkg::ST_EMPTY) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item settings, digit buffer, layout and output word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      wide_q  <= wide_i;
      dec_q   <= dcmd.dec;
      oct_q   <= (opcode_i == ifa_pkg::OP_OCT);
      upper_q <= (opcode_i == ifa_pkg::OP_UHEX) || (opcode_i == ifa_pkg::OP_PTR);
      alt_q   <= alt_form_i && ((opcode_i == ifa_pkg::OP_LHEX) ||
                                (opcode_i == ifa_pkg::OP_UHEX));
      left_q  <= left_justify_i;
      zero_q  <= zero_pad_i && !left_justify_i;
      sgn_q   <= neg || plus_sign_i || space_sign_i;
      sign_char_q <= neg ? ifa_pkg::CH_MINUS :
                     plus_sign_i ? ifa_pkg::CH_PLUS : ifa_pkg::CH_SPACE;
      width_q <= (field_width_i > 6'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : PW'(field_width_i);
      if (opcode_i == ifa_pkg::OP_PTR) begin
        prec_q <= PW'(ifa_pkg::PTR_PRECISION);
      end else if (count_given_i) begin
        prec_q <= (digit_count_i > 6'(MAX_PRECISION)) ? PW'(MAX_PRECISION)
                                                       : PW'(digit_count_i);
      end else begin
        prec_q <= PW'(1);
      end
    end
    if (dcmd.shift) begin
      digit_buf_q[nd_q[ifa_pkg::DIGIT_IDX_W-1:0]] <= dsts.digit;
    end
    if (state_q == ifa_pkg::ST_SIZE) begin
      nd_tot_q <= (PW'(nd_q) > prec_q) ? PW'(nd_q) : prec_q;
    end
    if (state_q == ifa_pkg::ST_PAD) begin
      body_q <= nd_tot_q + PW'(sgn_q);
      pad_q  <= (width_q > nd_tot_q + PW'(sgn_q)) ? width_q - nd_tot_q - PW'(sgn_q)
                                                   : PW'(0);
    end
    if (state_q == ifa_pkg::ST_PLACE) begin
      lead_q  <= lead_c;
      s_end_q <= s_end_c;
      a_end_q <= a_end_c;
      z_end_q <= z_end_c;
      d_end_q <= d_end_c;
      total_q <= total_c;
    end
    if (state_q == ifa_pkg::ST_EMIT && slot_free) begin
      out_char_q  <= emit_char;
      out_last_q  <= (k_q == total_q - PW'(1));
      out_empty_q <= 1'b0;
    end else if (state_q == ifa_pkg::ST_EMPTY && slot_free) begin
      out_char_q  <= ifa_pkg::CH_NUL;
      out_last_q  <= 1'b1;
      out_empty_q <= 1'b1;
    end
  end

  assign in_stall_o  = (state_q != ifa_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;
  assign empty_res_o = out_empty_q;

  // An accepted word holds off the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   accept |=> in_stall_o)
    else $error("input accepted twice in a row");

  // Emission never runs past the end of the field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ifa_pkg::ST_EMIT) |-> (k_q < total_q))
    else $error("character position beyond field end");

  // An empty word is always the last of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && empty_res_o) |-> last_o)
    else $error("empty word not marked last");

  // The digit buffer never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   dcmd.shift |-> (nd_q < ifa_pkg::DIGIT_CNT_W'(ifa_pkg::DIGIT_DEPTH)))
    else $error("digit buffer overflow");

  // The layout is only used after the digit string has been sized.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ifa_pkg::ST_PLACE) |-> (body_q == nd_tot_q + PW'(sgn_q)))
    else $error("field body size inconsistent");

  // The base flags of an item never both point to a decimal and octal string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ifa_pkg::ST_EXTRACT) |-> !(dec_q && oct_q))
    else $error("conflicting base flags");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to formatted ASCII unit: self-checking testbench
// Sends printf style integer conversion requests to the unit, works out the
// expected character stream of each accepted request and checks every word
// that leaves the unit against it. A directed set covers the corner cases
// and a random set follows, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  // Opcodes that the package does not name; they convert nothing.
  localparam logic [2:0] OP_UNDEF_A = 3'd6;
  localparam logic [2:0] OP_UNDEF_B = 3'd7;

  // Flag masks for building requests: {left, plus, space, alt, zero}.
  localparam logic [4:0] F_NONE  = 5'b00000;
  localparam logic [4:0] F_LEFT  = 5'b10000;
  localparam logic [4:0] F_PLUS  = 5'b01000;
  localparam logic [4:0] F_SPACE = 5'b00100;
  localparam logic [4:0] F_ALT   = 5'b00010;
  localparam logic [4:0] F_ZERO  = 5'b00001;

  // Cycles allowed for the unit to go quiet after the last expected word.
  localparam int SETTLE_CYCLES = 200;

  // One conversion request as carried by the input channel.
  typedef struct {
    logic [63:0] value;
    logic        wide;
    logic [2:0]  opcode;
    logic        left_justify;
    logic        plus_sign;
    logic        space_sign;
    logic        alt_form;
    logic        zero_pad;
    logic [5:0]  field_width;
    logic [5:0]  digit_count;
    logic        count_given;
  } fmt_req_t;

  // One character word as carried by the output channel.
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       empty;
  } char_word_t;

  // Works out the character stream of each request and checks the words.
  class format_scoreboard;
    char_word_t expected_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    // Formats one accepted request and queues the words it should give.
    function void note_request(fmt_req_t r);
      logic [63:0] mag;
      logic [63:0] radix;
      logic [31:0] lo;
      logic [3:0]  d;
      logic [7:0]  sign_ch;
      logic [7:0]  digits[$];
      logic [7:0]  line[$];
      int          wid;
      int          prec;
      int          body;
      int          pad;
      bit          upper;
      bit          zero_fill;
      bit          prefix;
      string       lut;
      char_word_t  w;
      if (r.opcode <= ifa_pkg::OP_PTR) begin
        wid = (r.field_width > ifa_pkg::MAX_WIDTH_DEF) ? ifa_pkg::MAX_WIDTH_DEF
                                                       : int'(r.field_width);
        if (r.count_given) begin
          prec = (r.digit_count > ifa_pkg::MAX_PRECISION_DEF) ? ifa_pkg::MAX_PRECISION_DEF
                                                              : int'(r.digit_count);
        end else begin
          prec = 1;
        end
        if (r.opcode == ifa_pkg::OP_PTR) prec = ifa_pkg::PTR_PRECISION;
        zero_fill = r.zero_pad && !r.left_justify;
        sign_ch = 8'h00;

        // Magnitude and sign: only a narrow decimal conversion is signed.
        if (r.wide) begin
          mag = r.value;
        end else begin
          lo = r.value[31:0];
          if (r.opcode == ifa_pkg::OP_DEC && lo[31]) begin
            sign_ch = ifa_pkg::CH_MINUS;
            lo = (~lo) + 32'd1;
          end
          mag = {32'd0, lo};
        end
        if (sign_ch == 8'h00) begin
          if (r.plus_sign) sign_ch = ifa_pkg::CH_PLUS;
          else if (r.space_sign) sign_ch = ifa_pkg::CH_SPACE;
        end

        radix = (r.opcode >= ifa_pkg::OP_LHEX) ? 64'd16
                                               : (r.opcode == ifa_pkg::OP_OCT ? 64'd8
                                                                              : 64'd10);
        upper = (r.opcode == ifa_pkg::OP_UHEX || r.opcode == ifa_pkg::OP_PTR);
        lut = upper ? "0123456789ABCDEF" : "0123456789abcdef";

        // Digits, most significant first, extended with zeros to the precision.
        while (mag != 64'd0) begin
          d = 4'(mag % radix);
          digits.push_front(lut[d]);
          mag = mag / radix;
        end
        while (digits.size() < prec) digits.push_front(ifa_pkg::CH_ZERO);

        body = digits.size() + ((sign_ch != 8'h00) ? 1 : 0);
        pad = (body < wid) ? wid - body : 0;
        prefix = r.alt_form && (r.opcode == ifa_pkg::OP_LHEX ||
                                r.opcode == ifa_pkg::OP_UHEX);

        // Assemble the field: space fill, sign, prefix, zero fill, digits.
        if (!r.left_justify && !zero_fill) repeat (pad) line.push_back(ifa_pkg::CH_SPACE);
        if (sign_ch != 8'h00) line.push_back(sign_ch);
        if (prefix) begin
          line.push_back(ifa_pkg::CH_ZERO);
          line.push_back(ifa_pkg::CH_LOW_X);
        end
        if (zero_fill) repeat (pad) line.push_back(ifa_pkg::CH_ZERO);
        foreach (digits[k]) line.push_back(digits[k]);
        if (r.left_justify) repeat (pad) line.push_back(ifa_pkg::CH_SPACE);
      end

      // An empty field still gives one word, marked as such.
      if (line.size() == 0) begin
        w.ch = ifa_pkg::CH_NUL;
        w.last = 1'b1;
        w.empty = 1'b1;
        expected_chars.push_back(w);
      end else begin
        foreach (line[k]) begin
          w.ch = line[k];
          w.last = (k == line.size() - 1);
          w.empty = 1'b0;
          expected_chars.push_back(w);
        end
      end
    endfunction

    // Compares one output word with the oldest expected one.
    function void check_word(logic [7:0] ch, logic last, logic empty);
      char_word_t w;
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: char %h last %b empty_res %b",
                 $time, ch, last, empty);
        return;
      end
      w = expected_chars.pop_front();
      if (ch !== w.ch) begin
        errors++;
        $display("%0t: out_char expected %h actual %h", $time, w.ch, ch);
      end
      if (last !== w.last) begin
        errors++;
        $display("%0t: last expected %b actual %b", $time, w.last, last);
      end
      if (empty !== w.empty) begin
        errors++;
        $display("%0t: empty_res expected %b actual %b", $time, w.empty, empty);
      end
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       out_stall_i = 1'b0;
  fmt_req_t   drv_req     = '{default: '0};
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_char_o;
  logic       last_o;
  logic       empty_res_o;

  // Idling switches for the sending and receiving sides.
  bit send_idle = 1'b0;
  bit sink_idle = 1'b0;

  format_scoreboard sb = new();

  integer_to_formatted_ascii_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (drv_req.value),
    .wide_i         (drv_req.wide),
    .opcode_i       (drv_req.opcode),
    .left_justify_i (drv_req.left_justify),
    .plus_sign_i    (drv_req.plus_sign),
    .space_sign_i   (drv_req.space_sign),
    .alt_form_i     (drv_req.alt_form),
    .zero_pad_i     (drv_req.zero_pad),
    .field_width_i  (drv_req.field_width),
    .digit_count_i  (drv_req.digit_count),
    .count_given_i  (drv_req.count_given),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .last_o         (last_o),
    .empty_res_o    (empty_res_o)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch both channels at the rising edge and feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(drv_req);
      if (out_valid_o && !out_stall_i) sb.check_word(out_char_o, last_o, empty_res_o);
    end
  end

  // Receiving side: stalls in random bursts while enabled.
  initial begin : sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 11) == 0) begin
        hold = $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Builds a request from its fields.
  function automatic fmt_req_t spec(logic [63:0] v, logic w, logic [2:0] op,
                                    logic [4:0] fl, logic [5:0] fw,
                                    logic [5:0] dc, logic g);
    fmt_req_t r;
    r.value = v;
    r.wide = w;
    r.opcode = op;
    {r.left_justify, r.plus_sign, r.space_sign, r.alt_form, r.zero_pad} = fl;
    r.field_width = fw;
    r.digit_count = dc;
    r.count_given = g;
    return r;
  endfunction

  // Random request: mostly valid conversions with modest sizes.
  function automatic fmt_req_t random_request();
    fmt_req_t r;
    case ($urandom_range(0, 6))
      0: r.value = 64'd0;
      1: r.value = 64'($urandom_range(0, 20));
      2: r.value = '1;
      3: r.value = 64'd1 << $urandom_range(0, 63);
      4: r.value = {$urandom, 32'h8000_0000 | $urandom};
      default: r.value = {$urandom, $urandom};
    endcase
    r.wide = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 19) == 0) begin
      r.opcode = $urandom_range(0, 1) ? OP_UNDEF_A : OP_UNDEF_B;
    end else begin
      r.opcode = 3'($urandom_range(ifa_pkg::OP_DEC, ifa_pkg::OP_PTR));
    end
    r.left_justify = 1'($urandom_range(0, 1));
    r.plus_sign = 1'($urandom_range(0, 1));
    r.space_sign = 1'($urandom_range(0, 1));
    r.alt_form = 1'($urandom_range(0, 1));
    r.zero_pad = 1'($urandom_range(0, 1));
    r.field_width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 12));
    r.digit_count = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 10));
    r.count_given = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Offers one word on the input channel and waits until it is taken.
  task automatic send(fmt_req_t r);
    int gap;
    gap = (send_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    drv_req <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Withdraws the input and waits until every expected word has come out.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Main sequence: reset, directed cases, random cases, final check.
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 1'b1;
    sink_idle = 1'b1;

    // Directed cases covering signs, saturation, prefixes and empty fields.
    send(spec(64'd0, 1'b0, ifa_pkg::OP_DEC, F_NONE, 6'd0, 6'd0, 1'b0));
    send(spec(64'h8000_0000, 1'b0, ifa_pkg::OP_DEC, F_NONE, 6'd0, 6'd0, 1'b0));
    send(spec(64'hFFFF_FFFF_7FFF_FFFF, 1'b0, ifa_pkg::OP_DEC, F_PLUS, 6'd0, 6'd0, 1'b0));
    send(spec('1, 1'b1, ifa_pkg::OP_DEC, F_SPACE, 6'd0, 6'd0, 1'b0));
    send(spec(64'hDEAD_BEEF_FFFF_FFFF, 1'b0, ifa_pkg::OP_UNS, F_NONE, 6'd0, 6'd0, 1'b0));
    send(spec('1, 1'b1, ifa_pkg::OP_OCT, F_ALT, 6'd0, 6'd0, 1'b0));
    send(spec(64'd0, 1'b0, ifa_pkg::OP_LHEX, F_ALT | F_ZERO, 6'd10, 6'd0, 1'b0));
    send(spec(64'h00C0_FFEE, 1'b0, ifa_pkg::OP_UHEX, F_ALT | F_PLUS | F_SPACE, 6'd12,
              6'd0, 1'b0));
    send(spec(64'h1234, 1'b1, ifa_pkg::OP_PTR, F_ALT, 6'd0, 6'd0, 1'b1));
    send(spec(64'hABCD_0000_1234, 1'b1, ifa_pkg::OP_PTR, F_ZERO, 6'd20, 6'd40, 1'b1));
    send(spec(64'd0, 1'b0, ifa_pkg::OP_DEC, F_NONE, 6'd0, 6'd0, 1'b1));
    send(spec(64'd0, 1'b1, ifa_pkg::OP_LHEX, F_LEFT, 6'd0, 6'd0, 1'b1));
    send(spec(64'd0, 1'b0, ifa_pkg::OP_UNS, F_PLUS, 6'd0, 6'd0, 1'b1));
    send(spec(64'd0, 1'b0, ifa_pkg::OP_DEC, F_SPACE, 6'd3, 6'd0, 1'b1));
    send(spec(64'd5, 1'b0, OP_UNDEF_A, F_NONE, 6'd4, 6'd2, 1'b1));
    send(spec('1, 1'b1, OP_UNDEF_B, F_PLUS, 6'd60, 6'd32, 1'b1));
    send(spec(64'hFFFF_FF85, 1'b0, ifa_pkg::OP_DEC, F_LEFT | F_ZERO, 6'd60, 6'd0, 1'b0));
    send(spec(64'd42, 1'b0, ifa_pkg::OP_DEC, F_NONE, 6'd63, 6'd63, 1'b1));
    send(spec(64'hFFFF_FFFE, 1'b0, ifa_pkg::OP_DEC, F_ZERO | F_PLUS, 6'd20, 6'd5, 1'b1));
    send(spec(64'd7, 1'b0, ifa_pkg::OP_DEC, F_LEFT | F_SPACE, 6'd63, 6'd32, 1'b1));
    // Widest field: sixty characters of fill, sign and digits, plus the prefix.
    send(spec('1, 1'b1, ifa_pkg::OP_LHEX, F_ALT | F_PLUS, 6'd60, 6'd0, 1'b0));
    send(spec(64'h0123_4567_89AB_CDEF, 1'b1, ifa_pkg::OP_LHEX, F_SPACE, 6'd0, 6'd20, 1'b1));
    send(spec(64'h8000_0000_0000_0000, 1'b1, ifa_pkg::OP_UNS, F_NONE, 6'd0, 6'd0, 1'b0));
    drain();

    // Random cases; idling switches in stretches and stops near the end.
    for (int i = 0; i < 77; i++) begin
      if (i % 10 == 0) begin
        send_idle = (i < 60) && ($urandom_range(0, 3) != 0);
        sink_idle = (i < 60) && ($urandom_range(0, 3) != 0);
      end
      if (i % 30 == 29) drain();
      send(random_request());
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Guard against a hung run.
  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/ifa_pkg.sv
rtl/ifa_digit_unit.sv
rtl/integer_to_formatted_ascii_unit.sv
tb/testbench.sv
